[rtl/core/dtfd_pkg.sv]
// Shared types, codes and helpers of the dual transport frame deframer.
`default_nettype none

package dtfd_pkg;

    localparam int LEN_WIDTH_DEF = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENC_REQUIRED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 1'd1;

    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd8192;

    localparam logic [7:0] IND_PLAIN = 8'h00;
    localparam logic [7:0] IND_ENC   = 8'h01;

    localparam logic [2:0] PH_IND   = 3'd0;
    localparam logic [2:0] PH_PLEN  = 3'd1;
    localparam logic [2:0] PH_PTYPE = 3'd2;
    localparam logic [2:0] PH_EHI   = 3'd3;
    localparam logic [2:0] PH_ELO   = 3'd4;
    localparam logic [2:0] PH_PAY   = 3'd5;

    localparam logic [2:0] EV_HDR     = 3'd0;
    localparam logic [2:0] EV_DONE    = 3'd1;
    localparam logic [2:0] EV_DATA    = 3'd2;
    localparam logic [2:0] EV_CLOSED  = 3'd3;
    localparam logic [2:0] EV_REJECT  = 3'd4;
    localparam logic [2:0] EV_IGNORED = 3'd5;

    localparam logic [1:0] TR_NONE  = 2'd0;
    localparam logic [1:0] TR_PLAIN = 2'd1;
    localparam logic [1:0] TR_ENC   = 2'd2;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  transport;
        logic [31:0] accum;
        logic [2:0]  vshift;
        logic [31:0] held_length;
        logic [15:0] held_type;
        logic [15:0] bytes_left;
        logic        closed;
    } dtfd_state_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  transport;
        logic [15:0] msg_type;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic        last;
    } dtfd_result_t;

    // Bit position of the seven payload bits of a varint byte.
    function automatic logic [4:0] varint_shamt(input logic [2:0] idx);
        logic [4:0] amt;
        case (idx)
            3'd0: amt = 5'd0;
            3'd1: amt = 5'd7;
            3'd2: amt = 5'd14;
            3'd3: amt = 5'd21;
            3'd4: amt = 5'd28;
            default: amt = 5'd0;
        endcase
        return amt;
    endfunction

endpackage

`default_nettype wire

[rtl/core/dtfd_core.sv]
// Next-state and result logic for one received byte of the deframer.
`default_nettype none

module dtfd_core import dtfd_pkg::*; #(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
    input  dtfd_state_t  st,
    input  logic [7:0]   rx_byte,
    input  logic         enc_required,
    input  logic [15:0]  max_payload,
    output dtfd_state_t  st_next,
    output dtfd_result_t res
);

    logic [31:0] vx;
    logic        finish;
    logic [31:0] fin_len;
    logic        over;
    logic [15:0] bl_dec;
    logic        ind_ok;
    logic        ind_reject;
    logic [1:0]  ind_tr;

    assign vx = st.accum | ({25'd0, rx_byte[6:0]} << varint_shamt(st.vshift));
    assign bl_dec = st.bytes_left - 16'd1;
    assign fin_len = (st.phase == PH_ELO) ? {st.held_length[31:8], rx_byte} : st.held_length;
    assign over = (fin_len > {16'd0, max_payload}) || ((fin_len >> LEN_WIDTH) != 32'd0);

    always_comb begin
        ind_ok = 1'b0;
        ind_reject = 1'b0;
        ind_tr = st.transport;
        case (st.transport)
            TR_NONE: begin
                if (rx_byte == IND_PLAIN) begin
                    ind_ok = !enc_required;
                    ind_reject = enc_required;
                    ind_tr = TR_PLAIN;
                end else if (rx_byte == IND_ENC) begin
                    ind_ok = enc_required;
                    ind_tr = TR_ENC;
                end
            end
            TR_PLAIN: ind_ok = (rx_byte == IND_PLAIN);
            TR_ENC:   ind_ok = (rx_byte == IND_ENC);
            default:  ind_ok = 1'b0;
        endcase
    end

    always_comb begin
        st_next = st;
        res = '0;
        finish = 1'b0;
        if (st.closed) begin
            res.event_res = EV_IGNORED;
        end else begin
            case (st.phase)
                PH_PLEN, PH_PTYPE: begin
                    if (rx_byte[7]) begin
                        if (st.vshift >= 3'd4) begin
                            st_next.closed = 1'b1;
                            res.event_res = EV_CLOSED;
                        end else begin
                            st_next.accum = vx;
                            st_next.vshift = st.vshift + 3'd1;
                            res.event_res = EV_HDR;
                        end
                    end else if (st.phase == PH_PLEN) begin
                        st_next.held_length = vx;
                        st_next.accum = '0;
                        st_next.vshift = '0;
                        st_next.phase = PH_PTYPE;
                        res.event_res = EV_HDR;
                    end else begin
                        st_next.held_type = vx[15:0];
                        st_next.accum = '0;
                        st_next.vshift = '0;
                        finish = 1'b1;
                    end
                end
                PH_EHI: begin
                    st_next.held_length = {16'd0, rx_byte, 8'd0};
                    st_next.phase = PH_ELO;
                    res.event_res = EV_HDR;
                end
                PH_ELO: begin
                    st_next.held_length = fin_len;
                    st_next.held_type = '0;
                    finish = 1'b1;
                end
                PH_PAY: begin
                    st_next.bytes_left = bl_dec;
                    if (bl_dec == 16'd0) begin
                        st_next.phase = PH_IND;
                    end
                    res.event_res = EV_DATA;
                    res.msg_type = st.held_type;
                    res.frame_length = st.held_length[15:0];
                    res.data_byte = rx_byte;
                    res.last = (bl_dec == 16'd0);
                end
                default: begin
                    if (!ind_ok) begin
                        st_next.closed = 1'b1;
                        res.event_res = ind_reject ? EV_REJECT : EV_CLOSED;
                    end else begin
                        st_next.transport = ind_tr;
                        st_next.held_length = '0;
                        st_next.held_type = '0;
                        st_next.accum = '0;
                        st_next.vshift = '0;
                        st_next.phase = (ind_tr == TR_PLAIN) ? PH_PLEN : PH_EHI;
                        res.event_res = EV_HDR;
                    end
                end
            endcase

            if (finish) begin
                if (over) begin
                    st_next.closed = 1'b1;
                    res.event_res = EV_CLOSED;
                end else begin
                    st_next.bytes_left = fin_len[15:0];
                    st_next.phase = (fin_len == 32'd0) ? PH_IND : PH_PAY;
                    res.event_res = EV_DONE;
                    res.msg_type = st_next.held_type;
                    res.frame_length = fin_len[15:0];
                    res.last = (fin_len == 32'd0);
                end
            end
        end
        res.transport = st_next.transport;
    end

endmodule

`default_nettype wire

[rtl/core/dual_transport_frame_deframer_top.sv]
// Top level of the dual transport frame deframer with its handshake and registers.
//
// The s_ channel carries one received byte per word. Each accepted byte gives
// exactly one word on the m_ channel: a header event, a header-done event with
// message type and payload length, a payload byte with its last mark, or a
// closed, reject or ignored event.
// The result of a byte accepted at one edge is registered and valid on the m_
// ports after that edge. Throughput is one byte per cycle when not stalled, set
// by the single result register; the whole per-byte decode sits in front of it.
// When the receiver stalls, the result register holds its word and s_ready
// drops until the word is taken; s_ready rises again in the cycle m_ready is
// high, so a stream keeps moving at full rate.
// The cfg channel is always ready. Register 0 is encryption_required and
// register 1 is max_payload; write them only while the block is idle.
// Reset clears the result valid flag and returns the link to its undecided,
// open state with encryption_required cleared and max_payload at 8192.
// After a close, every further byte gives an ignored event until reset.
`default_nettype none

module dual_transport_frame_deframer_top import dtfd_pkg::*; #(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_rx_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_event_res,
    output logic [1:0]                 m_transport,
    output logic [15:0]                m_msg_type,
    output logic [15:0]                m_frame_length,
    output logic [7:0]                 m_data_byte,
    output logic                       m_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dtfd_state_t  st_reg;
    dtfd_state_t  st_next;
    dtfd_result_t res_next;
    dtfd_result_t res_reg;
    logic         m_valid_reg;
    logic         enc_req_reg;
    logic [15:0]  max_payload_reg;
    logic         s_fire;
    logic         cfg_fire;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    dtfd_core #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_core (
        .st           (st_reg),
        .rx_byte      (s_rx_byte),
        .enc_required (enc_req_reg),
        .max_payload  (max_payload_reg),
        .st_next      (st_next),
        .res          (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enc_req_reg <= 1'b0;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_ENC_REQUIRED: enc_req_reg <= cfg_data[0];
                REG_MAX_PAYLOAD:  max_payload_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // The all-zero state is the awaiting-indicator phase on an undecided, open link.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (s_fire) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_res    = res_reg.event_res;
    assign m_transport    = res_reg.transport;
    assign m_msg_type     = res_reg.msg_type;
    assign m_frame_length = res_reg.frame_length;
    assign m_data_byte    = res_reg.data_byte;
    assign m_last         = res_reg.last;

endmodule

`default_nettype wire

[rtl/core/dtfd_checker.sv]
// Port-level assertions for the deframer top level and their bind.
`default_nettype none

module dtfd_checker import dtfd_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_event_res,
    input wire logic [1:0]  m_transport,
    input wire logic [15:0] m_msg_type,
    input wire logic [15:0] m_frame_length,
    input wire logic [7:0]  m_data_byte,
    input wire logic        m_last
);

    logic closed_seen_reg;
    logic closed_seen_next;

    assign closed_seen_next = closed_seen_reg ||
        (m_valid && m_ready && (m_event_res == EV_CLOSED || m_event_res == EV_REJECT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_seen_reg <= 1'b0;
        end else begin
            closed_seen_reg <= closed_seen_next;
        end
    end

    // A stalled word keeps its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_res) && $stable(m_data_byte)
            && $stable(m_frame_length) && $stable(m_last))
        else $error("result word changed while stalled");

    // Once the link has closed, only ignored events follow.
    a_closed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        closed_seen_reg && m_valid |-> m_event_res == EV_IGNORED)
        else $error("event other than ignored after close");

    // Close, reject and ignored words carry no frame information.
    a_close_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_res == EV_CLOSED || m_event_res == EV_REJECT
            || m_event_res == EV_IGNORED)
        |-> m_msg_type == 16'd0 && m_frame_length == 16'd0 && m_data_byte == 8'd0 && !m_last)
        else $error("closing word carries frame fields");

    // Payload bytes only flow on a decided transport.
    a_data_transport: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_res == EV_DATA |-> m_transport != TR_NONE)
        else $error("payload byte on undecided transport");

    // No word survives reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind dual_transport_frame_deframer_top dtfd_checker u_dtfd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_event_res    (m_event_res),
    .m_transport    (m_transport),
    .m_msg_type     (m_msg_type),
    .m_frame_length (m_frame_length),
    .m_data_byte    (m_data_byte),
    .m_last         (m_last)
);

`default_nettype wire

[tb/sv/dtfd_frame_checker.sv]
`timescale 1ns / 100ps
// Watches the deframer's channels, predicts each result word and compares it.
module dtfd_frame_checker import dtfd_pkg::*; #(
    parameter int LEN_WIDTH = LEN_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [2:0]            m_event_res,
    input  logic [1:0]            m_transport,
    input  logic [15:0]           m_msg_type,
    input  logic [15:0]           m_frame_length,
    input  logic [7:0]            m_data_byte,
    input  logic                  m_last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending_words,
    output int                    failures
);

    logic        enc_only;
    logic [15:0] payload_cap;

    logic [2:0]  link_phase;
    logic [1:0]  link_tr;
    logic [31:0] vacc;
    logic [2:0]  vpos;
    logic [31:0] held_len;
    logic [15:0] held_ty;
    logic [15:0] bytes_to_go;
    logic        link_down;

    dtfd_result_t expected_words[$];
    dtfd_result_t want;
    dtfd_result_t seen;
    int           mismatch_cnt = 0;

    function automatic dtfd_result_t make_word(input logic [2:0] ev, input logic [15:0] ty,
                                               input logic [15:0] len, input logic [7:0] data,
                                               input logic lst);
        dtfd_result_t w;
        w.event_res    = ev;
        w.transport    = link_tr;
        w.msg_type     = ty;
        w.frame_length = len;
        w.data_byte    = data;
        w.last         = lst;
        return w;
    endfunction

    function automatic dtfd_result_t close_link(input logic [2:0] ev);
        link_down = 1'b1;
        return make_word(ev, 16'd0, 16'd0, 8'd0, 1'b0);
    endfunction

    function automatic dtfd_result_t complete_header();
        logic [32:0] lim;
        lim = (33'd1 << LEN_WIDTH) - 33'd1;
        if (lim > {17'd0, payload_cap}) lim = {17'd0, payload_cap};
        if ({1'b0, held_len} > lim) return close_link(EV_CLOSED);
        bytes_to_go = held_len[15:0];
        link_phase = (held_len == 32'd0) ? PH_IND : PH_PAY;
        return make_word(EV_DONE, held_ty, held_len[15:0], 8'd0, held_len == 32'd0);
    endfunction

    function automatic dtfd_result_t decode_byte(input logic [7:0] b);
        logic [31:0] part;
        if (link_down) return make_word(EV_IGNORED, 16'd0, 16'd0, 8'd0, 1'b0);
        case (link_phase)
            PH_PLEN, PH_PTYPE: begin
                part = {25'd0, b[6:0]} << (7 * vpos);
                vacc = vacc | part;
                if (b[7]) begin
                    if (vpos >= 3'd4) return close_link(EV_CLOSED);
                    vpos = vpos + 3'd1;
                    return make_word(EV_HDR, 16'd0, 16'd0, 8'd0, 1'b0);
                end
                if (link_phase == PH_PLEN) begin
                    held_len = vacc;
                    vacc = 32'd0;
                    vpos = 3'd0;
                    link_phase = PH_PTYPE;
                    return make_word(EV_HDR, 16'd0, 16'd0, 8'd0, 1'b0);
                end
                held_ty = vacc[15:0];
                vacc = 32'd0;
                vpos = 3'd0;
                return complete_header();
            end
            PH_EHI: begin
                held_len = {16'd0, b, 8'd0};
                link_phase = PH_ELO;
                return make_word(EV_HDR, 16'd0, 16'd0, 8'd0, 1'b0);
            end
            PH_ELO: begin
                held_len = held_len | {24'd0, b};
                held_ty = 16'd0;
                return complete_header();
            end
            PH_PAY: begin
                bytes_to_go = bytes_to_go - 16'd1;
                if (bytes_to_go == 16'd0) link_phase = PH_IND;
                return make_word(EV_DATA, held_ty, held_len[15:0], b, bytes_to_go == 16'd0);
            end
            default: ;
        endcase
        if (link_tr == TR_NONE) begin
            if (b == IND_PLAIN) begin
                if (enc_only) return close_link(EV_REJECT);
                link_tr = TR_PLAIN;
            end else if (b == IND_ENC) begin
                if (!enc_only) return close_link(EV_CLOSED);
                link_tr = TR_ENC;
            end else begin
                return close_link(EV_CLOSED);
            end
        end else if ((link_tr == TR_PLAIN && b != IND_PLAIN) ||
                     (link_tr == TR_ENC && b != IND_ENC) ||
                     (link_tr != TR_PLAIN && link_tr != TR_ENC)) begin
            return close_link(EV_CLOSED);
        end
        held_len = 32'd0;
        held_ty = 16'd0;
        vacc = 32'd0;
        vpos = 3'd0;
        link_phase = (link_tr == TR_PLAIN) ? PH_PLEN : PH_EHI;
        return make_word(EV_HDR, 16'd0, 16'd0, 8'd0, 1'b0);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            enc_only = 1'b0;
            payload_cap = MAX_PAYLOAD_RST;
            link_phase = PH_IND;
            link_tr = TR_NONE;
            vacc = 32'd0;
            vpos = 3'd0;
            held_len = 32'd0;
            held_ty = 16'd0;
            bytes_to_go = 16'd0;
            link_down = 1'b0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.event_res    = m_event_res;
                seen.transport    = m_transport;
                seen.msg_type     = m_msg_type;
                seen.frame_length = m_frame_length;
                seen.data_byte    = m_data_byte;
                seen.last         = m_last;
                if (expected_words.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected word: ev=%0d tr=%0d type=%h len=%0d data=%h last=%0d",
                                 seen.event_res, seen.transport, seen.msg_type,
                                 seen.frame_length, seen.data_byte, seen.last);
                end else begin
                    want = expected_words.pop_front();
                    if (seen.event_res !== want.event_res || seen.transport !== want.transport ||
                        seen.msg_type !== want.msg_type ||
                        seen.frame_length !== want.frame_length ||
                        seen.data_byte !== want.data_byte || seen.last !== want.last) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: expected ev=%0d tr=%0d type=%h len=%0d data=%h last=%0d",
                                     want.event_res, want.transport, want.msg_type,
                                     want.frame_length, want.data_byte, want.last);
                            $display("          got      ev=%0d tr=%0d type=%h len=%0d data=%h last=%0d",
                                     seen.event_res, seen.transport, seen.msg_type,
                                     seen.frame_length, seen.data_byte, seen.last);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENC_REQUIRED: enc_only = cfg_data[0];
                    REG_MAX_PAYLOAD:  payload_cap = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_words.insert(expected_words.size(), decode_byte(s_rx_byte));
        end
        pending_words <= expected_words.size();
        failures <= mismatch_cnt;
    end

endmodule

[tb/sv/dual_transport_frame_deframer_top_tb.sv]
`timescale 1ns / 100ps
// Top of the deframer testbench: clock, reset, byte stimulus, register writes and verdict.
module dual_transport_frame_deframer_top_tb;
    import dtfd_pkg::*;

    localparam int LEN_WIDTH    = LEN_WIDTH_DEF;
    localparam int RANDOM_BYTES = 1500;
    localparam int PHASES       = 4;
    localparam int IDLE_PCT     = 22;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum int {RUN_PLAIN, RUN_ENC, RUN_REJECT, RUN_ENC_UNKEYED, RUN_BAD_FIRST} run_kind_t;
    typedef enum int {END_OPEN, END_BAD_IND, END_LONG_VARINT, END_OVER_LIMIT} end_kind_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = 8'd0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [2:0]            m_event_res;
    logic [1:0]            m_transport;
    logic [15:0]           m_msg_type;
    logic [15:0]           m_frame_length;
    logic [7:0]            m_data_byte;
    logic                  m_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   pending_words;
    int   failures;
    int   cycle_cnt = 0;
    int   bytes_sent = 0;
    int   max_now = MAX_PAYLOAD_RST;
    logic steady = 1'b0;
    logic plain_link = 1'b1;

    dual_transport_frame_deframer_top #(.LEN_WIDTH(LEN_WIDTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_res(m_event_res),
        .m_transport(m_transport), .m_msg_type(m_msg_type),
        .m_frame_length(m_frame_length), .m_data_byte(m_data_byte), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    dtfd_frame_checker #(.LEN_WIDTH(LEN_WIDTH)) u_frame_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_rx_byte(s_rx_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_event_res(m_event_res),
        .m_transport(m_transport), .m_msg_type(m_msg_type),
        .m_frame_length(m_frame_length), .m_data_byte(m_data_byte), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pending_words(pending_words), .failures(failures)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_random_bytes(input int n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == REG_MAX_PAYLOAD) max_now = val;
    endtask

    function automatic int varint_min_len(input logic [31:0] v);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 32'd0) n++;
        return n;
    endfunction

    task automatic send_varint(input logic [31:0] v, input int nbytes, input logic [2:0] spare_bits);
        int k;
        logic [7:0] b;
        for (k = 0; k < nbytes; k++) begin
            b = 8'((v >> (7 * k)) & 32'h7F);
            if (k == 4) b = b | {1'b0, spare_bits, 4'd0};
            if (k < nbytes - 1) b = b | 8'h80;
            send_byte(b);
        end
    endtask

    task automatic send_varint_any(input logic [31:0] v);
        int n;
        n = varint_min_len(v);
        if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 5);
        send_varint(v, n, 3'($urandom_range(0, 7)));
    endtask

    task automatic send_plain_header(input logic [31:0] len, input logic [31:0] ty);
        send_byte(IND_PLAIN);
        send_varint_any(len);
        send_varint_any(ty);
    endtask

    task automatic send_enc_header(input logic [15:0] len);
        send_byte(IND_ENC);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_random_frame();
        int hi;
        int r;
        logic [31:0] len;
        logic [31:0] ty;
        hi = (max_now < 24) ? max_now : 24;
        len = $urandom_range(0, hi);
        r = $urandom_range(0, 15);
        if (r == 0) len = (max_now < 300) ? max_now : $urandom_range(0, 300);
        else if (r == 1) len = 32'd0;
        if (plain_link) begin
            case ($urandom_range(0, 3))
                0: ty = $urandom_range(0, 127);
                1: ty = $urandom_range(0, 16383);
                2: ty = $urandom_range(0, 65535);
                default: ty = $urandom;
            endcase
            send_plain_header(len, ty);
        end else begin
            send_enc_header(len[15:0]);
        end
        send_random_bytes(len);
    endtask

    initial begin
        run_kind_t   run_kind;
        end_kind_t   end_kind;
        int          pick;
        int          ph;
        int          phase_start;
        logic [7:0]  b;
        logic [31:0] len;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        pick = $urandom_range(0, 15);
        if (pick == 0) run_kind = RUN_REJECT;
        else if (pick == 1) run_kind = RUN_ENC_UNKEYED;
        else if (pick == 2) run_kind = RUN_BAD_FIRST;
        else run_kind = pick[0] ? RUN_ENC : RUN_PLAIN;

        if (run_kind == RUN_REJECT || run_kind == RUN_ENC_UNKEYED || run_kind == RUN_BAD_FIRST) begin
            if (run_kind == RUN_REJECT) write_reg(REG_ENC_REQUIRED, 16'd1);
            else if (run_kind == RUN_ENC_UNKEYED) write_reg(REG_ENC_REQUIRED, 16'd0);
            else write_reg(REG_ENC_REQUIRED, 16'($urandom_range(0, 1)));
            write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(0, 65535)));
            if (run_kind == RUN_REJECT) send_byte(IND_PLAIN);
            else if (run_kind == RUN_ENC_UNKEYED) send_byte(IND_ENC);
            else send_byte(8'($urandom_range(2, 255)));
            send_random_bytes(RANDOM_BYTES);
        end else begin
            plain_link = (run_kind == RUN_PLAIN);
            write_reg(REG_ENC_REQUIRED, plain_link ? 16'd0 : 16'd1);
            write_reg(REG_MAX_PAYLOAD, 16'hFFFF);

            if (plain_link) begin
                // Empty frame, a five byte type with dropped high bits, a padded length
                // varint and a type wider than sixteen bits.
                send_byte(IND_PLAIN);
                send_varint(32'd0, 1, 3'd0);
                send_varint(32'd0, 1, 3'd0);
                send_byte(IND_PLAIN);
                send_varint(32'd1, 1, 3'd0);
                send_varint(32'hFFFF_FFFF, 5, 3'd7);
                send_byte(8'hFF);
                send_byte(IND_PLAIN);
                send_varint(32'd2, 5, 3'd0);
                send_varint(32'd300, 2, 3'd0);
                send_byte(8'h00);
                send_byte(8'h5A);
                send_byte(IND_PLAIN);
                send_varint(32'd0, 2, 3'd0);
                send_varint(32'h0001_2345, 3, 3'd0);
            end else begin
                send_enc_header(16'd0);
                send_enc_header(16'd1);
                send_byte(8'hFF);
                send_enc_header(16'd2);
                send_byte(8'h00);
                send_byte(8'hA5);
            end

            for (ph = 0; ph < PHASES; ph++) begin
                wait_idle();
                steady <= (ph == 1);
                case (ph)
                    0: write_reg(REG_MAX_PAYLOAD, 16'hFFFF);
                    1: write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(1, 40)));
                    2: write_reg(REG_MAX_PAYLOAD, 16'd0);
                    default: write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
                endcase
                if (ph > 0) write_reg(REG_ENC_REQUIRED, 16'($urandom_range(0, 1)));
                phase_start = bytes_sent;
                if (ph == 0) begin
                    if (plain_link) send_plain_header(32'd300, $urandom);
                    else send_enc_header(16'd300);
                    send_random_bytes(300);
                end
                while (bytes_sent - phase_start < RANDOM_BYTES / PHASES) send_random_frame();
            end

            end_kind = end_kind_t'($urandom_range(0, 3));
            if (!plain_link && end_kind == END_LONG_VARINT) end_kind = END_BAD_IND;
            case (end_kind)
                END_BAD_IND: begin
                    b = 8'($urandom_range(0, 255));
                    if (plain_link && b == IND_PLAIN) b = IND_ENC;
                    if (!plain_link && b == IND_ENC) b = IND_PLAIN;
                    send_byte(b);
                end
                END_LONG_VARINT: begin
                    send_byte(IND_PLAIN);
                    if ($urandom_range(0, 1) == 1) send_varint_any(32'($urandom_range(0, 20)));
                    repeat (5) send_byte(8'h80 | 8'($urandom_range(0, 127)));
                end
                END_OVER_LIMIT: begin
                    if (plain_link) begin
                        len = ($urandom_range(0, 1) == 1) ? max_now + 1 : ($urandom | 32'h0001_0000);
                        send_plain_header(len, $urandom);
                    end else begin
                        send_enc_header(16'($urandom_range(max_now + 1, 65535)));
                    end
                end
                default: ;
            endcase
            if (end_kind != END_OPEN) send_random_bytes(20);
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (failures == 0 && pending_words == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
